// File: rtl/core/mcd_pkg.sv
// Shared types, opcode values and the opcode classifier of the MPSSE command decoder.
package mcd_pkg;

   // One command for the shift engine or one response byte for the host.
   typedef struct packed {
      logic [2:0]  cmd_kind;
      logic [7:0]  cmd_data;
      logic [7:0]  aux_byte;
      logic [3:0]  bit_count;
      logic        drive_tdi;
      logic        do_read;
      logic [16:0] byte_count;
      logic [15:0] divisor;
      logic        last;
   } result_type;

   // Up to two results produced by one host byte, in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'b001,
      PHASE_ARGS   = 3'b010,
      PHASE_STREAM = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      CLASS_UNKNOWN,
      CLASS_NOP,
      CLASS_TWOARG,
      CLASS_BITS,
      CLASS_STREAM,
      CLASS_GETLOW,
      CLASS_GETHIGH,
      CLASS_FLUSH
   } class_type;

   // Command kinds seen by the shift engine.
   localparam logic [2:0] KIND_RESPONSE = 3'd0;
   localparam logic [2:0] KIND_SHIFT    = 3'd1;
   localparam logic [2:0] KIND_TMS      = 3'd2;
   localparam logic [2:0] KIND_SET_PINS = 3'd3;
   localparam logic [2:0] KIND_DIVISOR  = 3'd4;
   localparam logic [2:0] KIND_READ     = 3'd5;
   localparam logic [2:0] KIND_SAMPLE   = 3'd6;
   localparam logic [2:0] KIND_FLUSH    = 3'd7;

   // Opcodes.
   localparam logic [7:0] OP_SET_LOW      = 8'h80;
   localparam logic [7:0] OP_GET_LOW      = 8'h81;
   localparam logic [7:0] OP_SET_HIGH     = 8'h82;
   localparam logic [7:0] OP_GET_HIGH     = 8'h83;
   localparam logic [7:0] OP_LOOPBACK_ON  = 8'h84;
   localparam logic [7:0] OP_LOOPBACK_OFF = 8'h85;
   localparam logic [7:0] OP_DIVISOR      = 8'h86;
   localparam logic [7:0] OP_FLUSH        = 8'h87;

   localparam logic [7:0] OP_TMS_OUT_RISE = 8'h4A;
   localparam logic [7:0] OP_TMS_OUT_FALL = 8'h4B;
   localparam logic [7:0] OP_TMS_IO_RISE  = 8'h6A;
   localparam logic [7:0] OP_TMS_IO_FALL  = 8'h6B;

   localparam logic [7:0] OP_BITS_OUT_RISE   = 8'h12;
   localparam logic [7:0] OP_BITS_OUT_FALL   = 8'h13;
   localparam logic [7:0] OP_BITS_IN_RISE    = 8'h22;
   localparam logic [7:0] OP_BITS_IN_FALL    = 8'h26;
   localparam logic [7:0] OP_BITS_IO_RISE_A  = 8'h32;
   localparam logic [7:0] OP_BITS_IO_FALL_A  = 8'h33;
   localparam logic [7:0] OP_BITS_IO_RISE_B  = 8'h36;
   localparam logic [7:0] OP_BITS_IO_FALL_B  = 8'h37;

   localparam logic [7:0] OP_BYTES_OUT_RISE  = 8'h10;
   localparam logic [7:0] OP_BYTES_OUT_FALL  = 8'h11;
   localparam logic [7:0] OP_BYTES_IN_RISE   = 8'h20;
   localparam logic [7:0] OP_BYTES_IN_FALL   = 8'h24;
   localparam logic [7:0] OP_BYTES_IO_RISE_A = 8'h30;
   localparam logic [7:0] OP_BYTES_IO_FALL_A = 8'h31;
   localparam logic [7:0] OP_BYTES_IO_RISE_B = 8'h34;
   localparam logic [7:0] OP_BYTES_IO_FALL_B = 8'h35;

   // Opcode flag bits and response codes.
   localparam int         OP_WRITE_BIT     = 4;
   localparam int         OP_READ_BIT      = 5;
   localparam logic [7:0] RESP_BAD_COMMAND = 8'hFA;
   localparam logic [7:0] RESP_HIGH_PINS   = 8'h00;

   function automatic class_type classify(input logic [7:0] op);
      class_type cls;
      case (op) inside
         OP_LOOPBACK_ON, OP_LOOPBACK_OFF: cls = CLASS_NOP;
         OP_SET_LOW, OP_SET_HIGH, OP_DIVISOR,
         OP_TMS_OUT_RISE, OP_TMS_OUT_FALL,
         OP_TMS_IO_RISE, OP_TMS_IO_FALL: cls = CLASS_TWOARG;
         OP_BITS_OUT_RISE, OP_BITS_OUT_FALL, OP_BITS_IN_RISE, OP_BITS_IN_FALL,
         OP_BITS_IO_RISE_A, OP_BITS_IO_FALL_A,
         OP_BITS_IO_RISE_B, OP_BITS_IO_FALL_B: cls = CLASS_BITS;
         OP_BYTES_OUT_RISE, OP_BYTES_OUT_FALL, OP_BYTES_IN_RISE, OP_BYTES_IN_FALL,
         OP_BYTES_IO_RISE_A, OP_BYTES_IO_FALL_A,
         OP_BYTES_IO_RISE_B, OP_BYTES_IO_FALL_B: cls = CLASS_STREAM;
         OP_GET_LOW:  cls = CLASS_GETLOW;
         OP_GET_HIGH: cls = CLASS_GETHIGH;
         OP_FLUSH:    cls = CLASS_FLUSH;
         default:     cls = CLASS_UNKNOWN;
      endcase
      return cls;
   endfunction

endpackage

// File: rtl/core/mcd_channels.sv
// Request and response channel interfaces of the MPSSE command decoder.
interface mcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] host_byte;

   modport source (output valid, output host_byte, input ready);
   modport sink (input valid, input host_byte, output ready);
endinterface

interface mcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd_kind;
   logic [7:0]  cmd_data;
   logic [7:0]  aux_byte;
   logic [3:0]  bit_count;
   logic        drive_tdi;
   logic        do_read;
   logic [16:0] byte_count;
   logic [15:0] divisor;
   logic        last;

   modport source (output valid, output cmd_kind, output cmd_data, output aux_byte,
                   output bit_count, output drive_tdi, output do_read, output byte_count,
                   output divisor, output last, input ready);
   modport sink (input valid, input cmd_kind, input cmd_data, input aux_byte,
                 input bit_count, input drive_tdi, input do_read, input byte_count,
                 input divisor, input last, output ready);
endinterface

// File: rtl/core/mcd_decode.sv
// Input register and opcode parser: turns one host byte into zero to two results.
module mcd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   output mcd_pkg::push_type push
);

   logic                  stage_valid_ff, stage_valid_in;
   logic [7:0]            stage_byte_ff;
   mcd_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]            held_opcode_ff, held_opcode_in;
   logic                  args_seen_ff, args_seen_in;
   logic                  need_two_ff, need_two_in;
   logic [7:0]            first_arg_ff, first_arg_in;
   logic [16:0]           bytes_left_ff, bytes_left_in;
   logic                  stream_reads_ff, stream_reads_in;

   logic [7:0]            b;
   logic [7:0]            a0;
   logic [16:0]           stream_len;
   mcd_pkg::class_type    byte_class;
   mcd_pkg::class_type    held_class;

   assign stage_valid_in = in_accept;
   assign b              = stage_byte_ff;
   assign a0             = args_seen_ff ? first_arg_ff : b;
   assign stream_len     = {1'b0, b, a0} + 17'd1;
   assign byte_class     = mcd_pkg::classify(b);
   assign held_class     = mcd_pkg::classify(held_opcode_ff);

   always_comb begin
      phase_in        = phase_ff;
      held_opcode_in  = held_opcode_ff;
      args_seen_in    = args_seen_ff;
      need_two_in     = need_two_ff;
      first_arg_in    = first_arg_ff;
      bytes_left_in   = bytes_left_ff;
      stream_reads_in = stream_reads_ff;
      push            = '0;

      if (stage_valid_ff) begin
         case (phase_ff)
            mcd_pkg::PHASE_STREAM: begin
               // Each payload byte of a write stream becomes an eight-bit shift.
               push.count            = 2'd1;
               push.first.cmd_kind   = mcd_pkg::KIND_SHIFT;
               push.first.cmd_data   = b;
               push.first.bit_count  = 4'd8;
               push.first.drive_tdi  = 1'b1;
               push.first.do_read    = stream_reads_ff;
               push.first.last       = 1'b1;
               bytes_left_in         = bytes_left_ff - 17'd1;
               if (bytes_left_ff <= 17'd1) begin
                  phase_in = mcd_pkg::PHASE_IDLE;
               end
            end
            mcd_pkg::PHASE_ARGS: begin
               if (!args_seen_ff && need_two_ff) begin
                  first_arg_in = b;
                  args_seen_in = 1'b1;
               end else begin
                  if (!args_seen_ff) begin
                     first_arg_in = b;
                  end
                  phase_in     = mcd_pkg::PHASE_IDLE;
                  args_seen_in = 1'b0;
                  push.first.last = 1'b1;
                  case (held_class)
                     mcd_pkg::CLASS_BITS: begin
                        push.count              = 2'd1;
                        push.first.cmd_kind     = mcd_pkg::KIND_SHIFT;
                        push.first.drive_tdi    = held_opcode_ff[mcd_pkg::OP_WRITE_BIT];
                        push.first.do_read      = held_opcode_ff[mcd_pkg::OP_READ_BIT];
                        push.first.cmd_data     =
                           held_opcode_ff[mcd_pkg::OP_WRITE_BIT] ? b : 8'd0;
                        push.first.bit_count    = {1'b0, a0[2:0]} + 4'd1;
                     end
                     mcd_pkg::CLASS_STREAM: begin
                        stream_reads_in = held_opcode_ff[mcd_pkg::OP_READ_BIT];
                        if (held_opcode_ff[mcd_pkg::OP_WRITE_BIT]) begin
                           bytes_left_in = stream_len;
                           phase_in      = mcd_pkg::PHASE_STREAM;
                        end else begin
                           bytes_left_in         = 17'd0;
                           push.count            = 2'd1;
                           push.first.cmd_kind   = mcd_pkg::KIND_READ;
                           push.first.do_read    = 1'b1;
                           push.first.byte_count = stream_len;
                        end
                     end
                     default: begin
                        case (held_opcode_ff)
                           mcd_pkg::OP_DIVISOR: begin
                              push.count          = 2'd1;
                              push.first.cmd_kind = mcd_pkg::KIND_DIVISOR;
                              push.first.divisor  = {b, a0};
                           end
                           mcd_pkg::OP_SET_LOW: begin
                              push.count           = 2'd1;
                              push.first.cmd_kind  = mcd_pkg::KIND_SET_PINS;
                              push.first.cmd_data  = a0;
                              push.first.aux_byte  = b;
                           end
                           mcd_pkg::OP_TMS_OUT_RISE, mcd_pkg::OP_TMS_OUT_FALL,
                           mcd_pkg::OP_TMS_IO_RISE, mcd_pkg::OP_TMS_IO_FALL: begin
                              push.count           = 2'd1;
                              push.first.cmd_kind  = mcd_pkg::KIND_TMS;
                              push.first.cmd_data  = b;
                              push.first.bit_count = {1'b0, a0[2:0]} + 4'd1;
                              push.first.do_read   = held_opcode_ff[mcd_pkg::OP_READ_BIT];
                           end
                           default: begin
                              // Set high pins takes its arguments and gives nothing.
                              push.count = 2'd0;
                           end
                        endcase
                     end
                  endcase
               end
            end
            default: begin
               // Waiting for an opcode.
               push.first.last = 1'b1;
               case (byte_class)
                  mcd_pkg::CLASS_NOP: begin
                     push.count = 2'd0;
                  end
                  mcd_pkg::CLASS_TWOARG, mcd_pkg::CLASS_STREAM: begin
                     held_opcode_in = b;
                     need_two_in    = 1'b1;
                     args_seen_in   = 1'b0;
                     phase_in       = mcd_pkg::PHASE_ARGS;
                  end
                  mcd_pkg::CLASS_BITS: begin
                     held_opcode_in = b;
                     need_two_in    = b[mcd_pkg::OP_WRITE_BIT];
                     args_seen_in   = 1'b0;
                     phase_in       = mcd_pkg::PHASE_ARGS;
                  end
                  mcd_pkg::CLASS_GETLOW: begin
                     push.count          = 2'd1;
                     push.first.cmd_kind = mcd_pkg::KIND_SAMPLE;
                  end
                  mcd_pkg::CLASS_GETHIGH: begin
                     push.count           = 2'd1;
                     push.first.cmd_kind  = mcd_pkg::KIND_RESPONSE;
                     push.first.cmd_data  = mcd_pkg::RESP_HIGH_PINS;
                  end
                  mcd_pkg::CLASS_FLUSH: begin
                     push.count          = 2'd1;
                     push.first.cmd_kind = mcd_pkg::KIND_FLUSH;
                  end
                  default: begin
                     // Unknown opcode: bad-command code, then the opcode itself.
                     push.count            = 2'd2;
                     push.first.cmd_kind   = mcd_pkg::KIND_RESPONSE;
                     push.first.cmd_data   = mcd_pkg::RESP_BAD_COMMAND;
                     push.first.last       = 1'b0;
                     push.second.cmd_kind  = mcd_pkg::KIND_RESPONSE;
                     push.second.cmd_data  = b;
                     push.second.last      = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         phase_ff        <= mcd_pkg::PHASE_IDLE;
         held_opcode_ff  <= 8'd0;
         args_seen_ff    <= 1'b0;
         need_two_ff     <= 1'b0;
         first_arg_ff    <= 8'd0;
         bytes_left_ff   <= 17'd0;
         stream_reads_ff <= 1'b0;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         phase_ff        <= phase_in;
         held_opcode_ff  <= held_opcode_in;
         args_seen_ff    <= args_seen_in;
         need_two_ff     <= need_two_in;
         first_arg_ff    <= first_arg_in;
         bytes_left_ff   <= bytes_left_in;
         stream_reads_ff <= stream_reads_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         stage_byte_ff <= in_byte;
      end
   end

endmodule

// File: rtl/core/mcd_result_queue.sv
// Result queue taking up to two results a cycle and handing out one.
module mcd_result_queue #(
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcd_pkg::push_type          push,
   input  logic                       pop,
   output mcd_pkg::result_type        head,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mcd_pkg::result_type entry_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       wr_next;

   assign wr_next   = wr_ptr_ff + AW'(1);
   assign wr_ptr_in = wr_ptr_ff + AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// File: rtl/core/mpsse_command_decoder.sv
// Top level of the MPSSE command decoder: request channel, parser and result queue.
//
// Host command bytes enter on the request channel (req_chan), one byte per request.
// Each byte is an opcode, an argument or stream payload; the parser keeps the parse
// phase and collected arguments, and every byte yields zero, one or two results.
// Results leave on the response channel (rsp_chan) as commands for the JTAG shift
// engine or as response bytes for the host; last marks the final result of a byte.
// An accepted byte is held in the input register; its results are written into the
// result queue in the cycle after and appear on rsp_chan from the queue registers.
// Throughput: one request per cycle while the results keep up; a byte with an
// unknown opcode yields two results, which leave the response side one at a
// time. req_chan.ready depends only on the queue fill: it is high while at least
// four queue slots are free, enough for the byte in the input register and the
// byte being accepted, so the request side keeps moving while results wait.
// When the receiver stalls, results stay in the queue in order and requests are
// refused once fewer than four queue slots are free. Synchronous reset empties the
// queue and input register and returns the parser to waiting for an opcode.
module mpsse_command_decoder #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   mcd_req_if.sink   req_chan,
   mcd_rsp_if.source rsp_chan
);

   // The user keeps QUEUE_DEPTH a power of two and at least four; the block does not enforce it.
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   mcd_pkg::push_type   push;
   mcd_pkg::result_type head;
   logic [CW-1:0]       fill;
   logic                req_accept;
   logic                rsp_accept;

   // Room for two results from the staged byte and two from the new one.
   assign req_chan.ready = (fill <= CW'(QUEUE_DEPTH - 4));
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = (fill != '0);
   assign rsp_accept     = rsp_chan.valid && rsp_chan.ready;

   mcd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_chan.host_byte),
      .push      (push)
   );

   mcd_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_accept),
      .head  (head),
      .count (fill)
   );

   // The queue head drives the response payload straight from its registers.
   assign rsp_chan.cmd_kind   = head.cmd_kind;
   assign rsp_chan.cmd_data   = head.cmd_data;
   assign rsp_chan.aux_byte   = head.aux_byte;
   assign rsp_chan.bit_count  = head.bit_count;
   assign rsp_chan.drive_tdi  = head.drive_tdi;
   assign rsp_chan.do_read    = head.do_read;
   assign rsp_chan.byte_count = head.byte_count;
   assign rsp_chan.divisor    = head.divisor;
   assign rsp_chan.last       = head.last;

endmodule
